// ===== rtl/ngi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngi_pkg
// Shared types and constants of the n-gram index builder: field widths,
// parameter defaults, item action codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ngi_pkg;

    // Default sizes of the alphabet store and of the longest n-gram.
    localparam int ALPHABET_MAX_DEF = 128;
    localparam int NGRAM_MAX_DEF    = 6;

    // Field widths of input items, result items and registers.
    localparam int SLOT_W       = 7;
    localparam int SYMBOL_W     = 8;
    localparam int POS_W        = 42;
    localparam int RADIX_W      = 8;
    localparam int NGRAM_LEN_W  = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 48;

    // Register values after reset.
    localparam logic [RADIX_W-1:0]     ALPHABET_SIZE_RST = 8'd128;
    localparam logic [NGRAM_LEN_W-1:0] NGRAM_LEN_RST     = 3'd3;

    // What an input item does.
    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_CHAR = 1'b1
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHABET_SIZE = 1'b0,
        REG_NGRAM_LEN     = 1'b1
    } cfg_reg_t;

endpackage

// ===== rtl/ngram_to_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngram_to_index
// Builds the mixed-radix table index of an n-gram from a stream of load and
// character items, with a parallel alphabet compare and one multiply-add.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, loads and characters alike, unless a completed
// n-gram waits on the result side. A result passes the digit register, then the
// result register, after the edge that accepts the last character of its n-gram.
// The alphabet compare sits in the first stage, the multiply-add in the second.
// Reset clears all control state and the n-gram state and returns the
// configuration registers to their defaults; the alphabet store is not cleared.
module ngram_to_index #(
    parameter int ALPHABET_MAX = ngi_pkg::ALPHABET_MAX_DEF,
    parameter int NGRAM_MAX    = ngi_pkg::NGRAM_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ngi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ngi_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: slot [6:0], symbol [14:7], zero fill [15].
    input  logic [ngi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: action [0].
    input  logic                              s_axis_tuser,
    // Result items.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: position [41:0], zero fill [47:42].
    output logic [ngi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // Fields from bit 0: found [0].
    output logic                              m_axis_tuser
);

    localparam int POS_W   = ngi_pkg::POS_W;
    localparam int RADIX_W = ngi_pkg::RADIX_W;
    localparam int SLOT_W  = ngi_pkg::SLOT_W;
    localparam int SYM_W   = ngi_pkg::SYMBOL_W;
    localparam int DIG_W   = $clog2(ALPHABET_MAX);
    localparam int CNT_W   = $clog2(NGRAM_MAX + 1);
    localparam int LEN_W   = (CNT_W > ngi_pkg::NGRAM_LEN_W) ? CNT_W : ngi_pkg::NGRAM_LEN_W;

    // Configuration registers.
    logic [RADIX_W-1:0]               alphabet_size_reg;
    logic [ngi_pkg::NGRAM_LEN_W-1:0]  ngram_len_reg;

    // Alphabet store, one compare lane per entry.
    logic [SYM_W-1:0]                 store_reg [ALPHABET_MAX];

    // Stage 1: input register.
    logic                             s1_valid_reg;
    ngi_pkg::action_t                 s1_action_reg;
    logic [SLOT_W-1:0]                s1_slot_reg;
    logic [SYM_W-1:0]                 s1_symbol_reg;

    // Stage 2: digit register.
    logic                             s2_valid_reg;
    logic [DIG_W-1:0]                 s2_digit_reg;
    logic                             s2_found_reg;

    // N-gram state.
    logic [POS_W-1:0]                 acc_reg;
    logic [POS_W-1:0]                 acc_next;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [CNT_W-1:0]                 cnt_next;
    logic                             matched_reg;
    logic                             matched_next;

    // Result register.
    logic                             out_valid_reg;
    logic [POS_W-1:0]                 out_pos_reg;
    logic                             out_found_reg;

    // Handshake and datapath signals.
    logic                             in_accept;
    logic                             out_free;
    logic                             s1_adv;
    logic                             s2_take;
    logic                             s2_go;
    logic                             completes;
    logic                             load_go;
    logic [ALPHABET_MAX-1:0]          hit;
    logic [ALPHABET_MAX-1:0]          hit_low;
    logic [DIG_W-1:0]                 digit;
    logic                             found;
    logic [POS_W+RADIX_W-1:0]         prod;
    logic [CNT_W-1:0]                 cnt_inc;
    logic [LEN_W-1:0]                 len_ext;
    logic [LEN_W-1:0]                 eff_len;

    // Configuration port accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_size_reg <= ngi_pkg::ALPHABET_SIZE_RST;
            ngram_len_reg     <= ngi_pkg::NGRAM_LEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (ngi_pkg::cfg_reg_t'(cfg_index))
                ngi_pkg::REG_ALPHABET_SIZE: alphabet_size_reg <= cfg_data[RADIX_W-1:0];
                ngi_pkg::REG_NGRAM_LEN:     ngram_len_reg <= cfg_data[ngi_pkg::NGRAM_LEN_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Flow control: each stage moves when the stage after it has room.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s2_go         = s2_valid_reg && (!completes || out_free);
    assign s2_take       = !s2_valid_reg || s2_go;
    assign s1_adv        = s1_valid_reg && ((s1_action_reg == ngi_pkg::ACT_LOAD) || s2_take);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign load_go       = s1_adv && (s1_action_reg == ngi_pkg::ACT_LOAD);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= ngi_pkg::action_t'(s_axis_tuser);
            s1_slot_reg   <= s_axis_tdata[SLOT_W-1:0];
            s1_symbol_reg <= s_axis_tdata[SLOT_W+SYM_W-1:SLOT_W];
        end
    end

    // Load items write one entry; slots beyond the store are dropped.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ALPHABET_MAX; i++)
        begin
            if (load_go && (int'(s1_slot_reg) == i))
            begin
                store_reg[i] <= s1_symbol_reg;
            end
        end
    end

    // Parallel compare against the active part of the alphabet.
    always_comb
    begin
        for (int i = 0; i < ALPHABET_MAX; i++)
        begin
            hit[i] = (store_reg[i] == s1_symbol_reg) && (i < int'(alphabet_size_reg))
                     && (s1_symbol_reg != '0);
        end
    end

    // The lowest matching slot is the digit; no match gives digit zero.
    assign hit_low = hit & (~hit + ALPHABET_MAX'(1));
    assign found   = |hit;

    always_comb
    begin
        digit = '0;
        for (int i = 0; i < ALPHABET_MAX; i++)
        begin
            if (hit_low[i])
            begin
                digit = digit | DIG_W'(i);
            end
        end
    end

    // Digit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_take)
        begin
            s2_valid_reg <= s1_valid_reg && (s1_action_reg == ngi_pkg::ACT_CHAR);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && s1_adv)
        begin
            s2_digit_reg <= digit;
            s2_found_reg <= found;
        end
    end

    // Effective n-gram length: zero acts as one, clamped to the maximum.
    assign len_ext = LEN_W'(ngram_len_reg);

    always_comb
    begin
        priority if (len_ext == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_ext > LEN_W'(NGRAM_MAX))
        begin
            eff_len = LEN_W'(NGRAM_MAX);
        end
        else
        begin
            eff_len = len_ext;
        end
    end

    // Multiply-add of the accumulator, wrapping at the position width.
    assign prod      = acc_reg * alphabet_size_reg;
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign completes = LEN_W'(cnt_inc) >= eff_len;

    always_comb
    begin
        acc_next     = prod[POS_W-1:0] + POS_W'(s2_digit_reg);
        cnt_next     = cnt_inc;
        matched_next = matched_reg && s2_found_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            cnt_reg     <= '0;
            matched_reg <= 1'b1;
        end
        else if (s2_go)
        begin
            if (completes)
            begin
                acc_reg     <= '0;
                cnt_reg     <= '0;
                matched_reg <= 1'b1;
            end
            else
            begin
                acc_reg     <= acc_next;
                cnt_reg     <= cnt_next;
                matched_reg <= matched_next;
            end
        end
    end

    // Result register; the position reads zero when a character was missing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_go && completes;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_go && completes)
        begin
            out_pos_reg   <= matched_next ? acc_next : '0;
            out_found_reg <= matched_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ngi_pkg::OUT_TDATA_W'(out_pos_reg);
    assign m_axis_tuser  = out_found_reg;

    // A completed n-gram leaves the n-gram state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && completes) |=> (acc_reg == '0 && cnt_reg == '0 && matched_reg))
    else $error("n-gram state not cleared after a result");

    // A result without all characters found carries position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_pos_reg == '0))
    else $error("position not zero for a missing character");

    // The character count never reaches the longest n-gram.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) < NGRAM_MAX)
    else $error("character count out of range");

    // The input only stalls behind a character blocked in the digit stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> (s2_valid_reg && completes && out_valid_reg
                                       && !m_axis_tready))
    else $error("input stalled without a blocked result");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the n-gram index builder. A queue of load and
// character items feeds a bursty stream driver; a behavioral index model
// predicts each result item at the accepting edge, and a monitor compares
// every result item against the oldest prediction while the result side
// stalls on its own pattern. The run steps through several radix and length
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SLOT_W           = ngi_pkg::SLOT_W;
    localparam int SYMBOL_W         = ngi_pkg::SYMBOL_W;
    localparam int POS_W            = ngi_pkg::POS_W;
    localparam int RADIX_W          = ngi_pkg::RADIX_W;
    localparam int NGRAM_LEN_W      = ngi_pkg::NGRAM_LEN_W;
    localparam int CFG_DATA_W       = ngi_pkg::CFG_DATA_W;
    localparam int IN_TDATA_W       = ngi_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W      = ngi_pkg::OUT_TDATA_W;
    localparam int ALPHABET_MAX_DEF = ngi_pkg::ALPHABET_MAX_DEF;
    localparam int NGRAM_MAX_DEF    = ngi_pkg::NGRAM_MAX_DEF;

    // Input item as the driver sees it.
    typedef struct packed {
        ngi_pkg::action_t      action;
        logic [SLOT_W-1:0]     slot;
        logic [SYMBOL_W-1:0]   symbol;
    } ngram_item_t;

    // One predicted result item.
    typedef struct packed {
        logic [POS_W-1:0]      position;
        logic                  found;
    } index_result_t;

    // Result-side stall patterns.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_PERIODIC
    } sink_mode_t;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 8;
    localparam int PHASE_ITEMS      = 120;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    ngi_pkg::cfg_reg_t         cfg_index = ngi_pkg::REG_ALPHABET_SIZE;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata = '0;
    logic                      s_axis_tuser = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                      m_axis_tuser;

    ngram_to_index dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus backlog, predictions and bookkeeping.
    ngram_item_t               item_backlog[$];
    index_result_t             index_expected[$];
    int                        items_queued = 0;
    int                        items_accepted = 0;
    int                        mismatches = 0;

    // Alphabet as the stimulus generator expects it when its items arrive.
    logic [SYMBOL_W-1:0]       gen_alpha[ALPHABET_MAX_DEF];

    // Index model state and its copy of the configuration.
    logic [SYMBOL_W-1:0]       alpha_mirror[ALPHABET_MAX_DEF];
    logic [POS_W-1:0]          acc = '0;
    int                        chars_seen = 0;
    logic                      all_hit = 1'b1;
    logic [RADIX_W-1:0]        radix_now = ngi_pkg::ALPHABET_SIZE_RST;
    logic [NGRAM_LEN_W-1:0]    len_now = ngi_pkg::NGRAM_LEN_RST;

    // Long hold-off request from the sequence to the result side.
    logic [3:0]                hold_req = '0;
    logic [3:0]                hold_ack = '0;

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Characters per n-gram once the length register is clamped.
    function automatic int span();
        int n;
        n = int'(len_now);
        if (n == 0)
            n = 1;
        if (n > NGRAM_MAX_DEF)
            n = NGRAM_MAX_DEF;
        return n;
    endfunction

    // Slots that take part in the lookup under the current radix.
    function automatic int search_limit();
        return (radix_now > ALPHABET_MAX_DEF) ? ALPHABET_MAX_DEF : int'(radix_now);
    endfunction

    // Advances the index model by one accepted item.
    task automatic index_predict(input ngram_item_t it);
        int            limit;
        int            i;
        logic          hit;
        logic [POS_W-1:0] radix_w;
        logic [POS_W-1:0] digit_w;
        index_result_t res;
        if (it.action == ngi_pkg::ACT_LOAD)
        begin
            alpha_mirror[it.slot] = it.symbol;
            return;
        end
        limit = search_limit();
        hit = 1'b0;
        digit_w = '0;
        // Lowest matching slot wins; a zero byte never matches.
        if (it.symbol != '0)
        begin
            for (i = 0; i < limit && !hit; i++)
            begin
                if (alpha_mirror[i] == it.symbol)
                begin
                    hit = 1'b1;
                    digit_w = POS_W'(i);
                end
            end
        end
        if (!hit)
            all_hit = 1'b0;
        radix_w = POS_W'(radix_now);
        acc = acc * radix_w + digit_w;
        chars_seen++;
        if (chars_seen >= span())
        begin
            res.position = all_hit ? acc : '0;
            res.found = all_hit;
            index_expected.push_back(res);
            acc = '0;
            chars_seen = 0;
            all_hit = 1'b1;
        end
    endtask

    task automatic queue_item(input ngi_pkg::action_t act, input logic [SLOT_W-1:0] slot,
                              input logic [SYMBOL_W-1:0] sym);
        ngram_item_t it;
        it.action = act;
        it.slot = slot;
        it.symbol = sym;
        if (act == ngi_pkg::ACT_LOAD)
            gen_alpha[slot] = sym;
        item_backlog.push_back(it);
        items_queued++;
    endtask

    // A symbol held by some searched slot, found unless it is zero; a random one when none is searched.
    function automatic logic [SYMBOL_W-1:0] hit_symbol();
        int limit;
        limit = search_limit();
        if (limit == 0)
            return SYMBOL_W'($urandom_range(1, 255));
        return gen_alpha[$urandom_range(0, limit - 1)];
    endfunction

    // A nonzero symbol held by no searched slot, or zero if none is left.
    function automatic logic [SYMBOL_W-1:0] miss_symbol();
        int   limit;
        int   start;
        int   k;
        int   i;
        int   s;
        logic taken;
        limit = search_limit();
        start = $urandom_range(0, 255);
        for (k = 0; k < 256; k++)
        begin
            s = (start + k) % 256;
            if (s != 0)
            begin
                taken = 1'b0;
                for (i = 0; i < limit; i++)
                    if (gen_alpha[i] == s)
                        taken = 1'b1;
                if (!taken)
                    return SYMBOL_W'(s);
            end
        end
        return '0;
    endfunction

    // Mostly complete n-grams of found characters, with loads mixed in,
    // plus noisy characters and runs that break off early.
    task automatic queue_ngrams(input int groups, input int clean_pct);
        int                  eff;
        int                  k;
        logic                clean;
        logic [SYMBOL_W-1:0] sym;
        repeat (groups)
        begin
            eff = span();
            if ($urandom_range(0, 99) < 8)
                eff = int'($urandom_range(1, eff));
            clean = ($urandom_range(0, 99) < clean_pct);
            for (k = 0; k < eff; k++)
            begin
                if ($urandom_range(0, 99) < 12)
                    queue_item(ngi_pkg::ACT_LOAD, SLOT_W'($urandom_range(0, 127)),
                               SYMBOL_W'($urandom_range(0, 255)));
                if (clean)
                    sym = hit_symbol();
                else
                begin
                    case ($urandom_range(0, 3))
                        0: sym = miss_symbol();
                        1: sym = SYMBOL_W'($urandom_range(0, 255));
                        2: sym = '0;
                        default: sym = hit_symbol();
                    endcase
                end
                queue_item(ngi_pkg::ACT_CHAR, SLOT_W'($urandom_range(0, 127)), sym);
            end
        end
    endtask

    // Waits until every queued item is in and every result has come out,
    // then lets the pipeline settle.
    task automatic drain_results();
        while (items_accepted != items_queued || index_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input ngi_pkg::cfg_reg_t idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == ngi_pkg::REG_ALPHABET_SIZE)
            radix_now = data[RADIX_W-1:0];
        else
            len_now = data[NGRAM_LEN_W-1:0];
    endtask

    // Both registers are written with the block idle; spare bits of the
    // length write carry random values.
    task automatic set_geometry(input logic [RADIX_W-1:0] radix,
                                input logic [NGRAM_LEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] len_word;
        drain_results();
        len_word = CFG_DATA_W'($urandom_range(0, 255));
        len_word[NGRAM_LEN_W-1:0] = len;
        write_register(ngi_pkg::REG_ALPHABET_SIZE, radix);
        write_register(ngi_pkg::REG_NGRAM_LEN, len_word);
    endtask

    // Stream driver: bursts of random length separated by random gaps.
    ngram_item_t in_flight;
    int          burst_left = 1;
    int          gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                index_predict(in_flight);
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0 || item_backlog.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    in_flight = item_backlog.pop_front();
                    s_axis_tdata  <= {1'b0, in_flight.symbol, in_flight.slot};
                    s_axis_tuser  <= in_flight.action;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // Result-side ready: rotating stall patterns, plus a long hold-off on request.
    sink_mode_t sink_mode = SINK_OPEN;
    int         mode_left = 0;
    int         hold_left = 0;
    logic [7:0] rx_cycle = '0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            mode_left     <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 8'd1;
            if (hold_ack != hold_req)
            begin
                hold_ack      <= hold_req;
                hold_left     <= LONG_HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    sink_mode <= sink_mode_t'($urandom_range(0, 3));
                    mode_left <= $urandom_range(20, 200);
                end
                else
                    mode_left <= mode_left - 1;
                case (sink_mode)
                    SINK_OPEN:     m_axis_tready <= 1'b1;
                    SINK_COIN:     m_axis_tready <= ($urandom_range(0, 1) == 1);
                    SINK_MOSTLY:   m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default:       m_axis_tready <= (rx_cycle[2:0] < 3'd3);
                endcase
            end
        end
    end

    // Result monitor: each accepted result against the oldest prediction.
    index_result_t seen_want;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (index_expected.size() == 0)
                flag_mismatch($sformatf("result item with none expected, position %0d found %0b",
                                        m_axis_tdata[POS_W-1:0], m_axis_tuser));
            else
            begin
                seen_want = index_expected.pop_front();
                if (m_axis_tdata[POS_W-1:0] !== seen_want.position)
                    flag_mismatch($sformatf("position %0d, expected %0d",
                                            m_axis_tdata[POS_W-1:0], seen_want.position));
                if (m_axis_tuser !== seen_want.found)
                    flag_mismatch($sformatf("found %0b, expected %0b",
                                            m_axis_tuser, seen_want.found));
            end
        end
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Test sequence.
    initial
    begin
        int i;
        for (i = 0; i < ALPHABET_MAX_DEF; i++)
        begin
            gen_alpha[i] = '0;
            alpha_mirror[i] = '0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every slot before any lookup; duplicates occur naturally.
        for (i = 0; i < ALPHABET_MAX_DEF; i++)
            queue_item(ngi_pkg::ACT_LOAD, SLOT_W'(i), SYMBOL_W'($urandom_range(1, 255)));

        // Directed items under the reset configuration.
        queue_item(ngi_pkg::ACT_LOAD, 7'd0, 8'h00);
        queue_item(ngi_pkg::ACT_LOAD, 7'd127, 8'hFF);
        queue_item(ngi_pkg::ACT_LOAD, 7'd126, gen_alpha[2]);
        // Largest symbol three times.
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, 8'hFF);
        queue_item(ngi_pkg::ACT_CHAR, 7'd127, 8'hFF);
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, 8'hFF);
        // Zero byte is never found, even though slot 0 holds zero.
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, 8'h00);
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, hit_symbol());
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, hit_symbol());
        // Missing character in the middle.
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, hit_symbol());
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, miss_symbol());
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, hit_symbol());
        // A load inside an n-gram leaves the partial index alone.
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, hit_symbol());
        queue_item(ngi_pkg::ACT_LOAD, 7'd64, SYMBOL_W'($urandom_range(1, 255)));
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, hit_symbol());
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, hit_symbol());
        // Duplicated symbol resolves to the lowest slot.
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, gen_alpha[2]);
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, gen_alpha[126]);
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, gen_alpha[2]);
        // Leave one character pending across the next setting.
        queue_item(ngi_pkg::ACT_CHAR, 7'd0, hit_symbol());
        queue_ngrams(PHASE_ITEMS / (span() + 1), 75);

        // Widest radix and longest n-gram: the index wraps.
        set_geometry(8'd255, 3'd6);
        queue_ngrams(PHASE_ITEMS / (span() + 1), 75);

        // Radix zero finds nothing.
        set_geometry(8'd0, 3'd2);
        queue_ngrams(PHASE_ITEMS / (span() + 1), 75);

        // Radix one, single characters.
        set_geometry(8'd1, 3'd1);
        queue_ngrams(PHASE_ITEMS / (span() + 1), 75);

        // Length above the maximum acts as the maximum.
        set_geometry(8'd2, 3'd7);
        queue_ngrams(PHASE_ITEMS / (span() + 1), 75);

        // Length zero acts as one; the result side holds off for a long
        // stretch while characters keep coming, so the block backs up.
        set_geometry(8'd128, 3'd0);
        queue_ngrams(300, 80);
        hold_req <= hold_req + 4'd1;

        set_geometry(8'd37, 3'd4);
        queue_ngrams(PHASE_ITEMS / (span() + 1), 75);

        set_geometry(8'd200, 3'd5);
        queue_ngrams(PHASE_ITEMS / (span() + 1), 75);

        set_geometry(ngi_pkg::ALPHABET_SIZE_RST, ngi_pkg::NGRAM_LEN_RST);
        queue_ngrams(PHASE_ITEMS / (span() + 1), 75);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && index_expected.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
